// ===== src/mexp_pkg.sv =====
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared constants and types for the modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

    // Width of the operand, exponent and result ports
    localparam int FIELD_WIDTH       = 32;
    // Default number of operand bits actually used
    localparam int OPERAND_WIDTH_DEF = 32;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED_WAIT,
        S_STEP,
        S_MUL_WAIT,
        S_SQR_WAIT,
        S_DONE
    } t_state;

endpackage

// ===== src/modular_exponentiation.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation
// Right-to-left square-and-multiply: power_result = base^exponent mod modulus.
// ----------------------------------------------------------------------------
// One item at a time: busy is high from the start transfer until the result
// strobe. All arithmetic runs through one bit-serial modular multiplier. An
// item costs one base reduction, then per exponent bit up to its highest set
// bit a step state, a squaring (skipped after the top bit) and, on a set bit,
// one multiply. A zero exponent gives 1 in the cycle right after the start
// transfer.
// o_valid is high for exactly one cycle; the receiver must take the result
// then. The modulus is written through the cfg channel (always ready); the
// user must write it only while the block is idle, which the block itself does
// not enforce. A write of zero is ignored, reset value is 1.
// ----------------------------------------------------------------------------
module modular_exponentiation
    import mexp_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [FIELD_WIDTH-1:0] i_cfg_data,
    input  logic                   start,
    output logic                   busy,
    input  logic [FIELD_WIDTH-1:0] i_base_value,
    input  logic [FIELD_WIDTH-1:0] i_exponent,
    output logic                   o_valid,
    output logic [FIELD_WIDTH-1:0] o_power_result
);

    localparam int W = OPERAND_WIDTH;

    t_state       r_state, n_state;
    logic [W-1:0] r_modulus;
    logic [W-1:0] r_acc, n_acc;
    logic [W-1:0] r_pw,  n_pw;
    logic [W-1:0] r_exp, n_exp;

    logic         mul_start;
    logic [W-1:0] mul_a;
    logic [W-1:0] mul_b;
    logic         mul_done;
    logic [W-1:0] mul_result;
    logic [W-1:0] one_mod;

    // Configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= W'(1);
        end else if (i_cfg_valid && (i_cfg_data[W-1:0] != '0)) begin
            r_modulus <= i_cfg_data[W-1:0];
        end
    end

    // 1 mod m, so the base reduction multiplicand is below m
    assign one_mod = (r_modulus == W'(1)) ? '0 : W'(1);

    mexp_mulmod #(
        .OPERAND_WIDTH(W)
    ) u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .i_m     (r_modulus),
        .o_done  (mul_done),
        .o_result(mul_result)
    );

    always_comb begin
        n_state   = r_state;
        n_acc     = r_acc;
        n_pw      = r_pw;
        n_exp     = r_exp;
        mul_start = 1'b0;
        mul_a     = r_pw;
        mul_b     = r_pw;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_acc = W'(1);
                    n_exp = i_exponent[W-1:0];
                    if (i_exponent[W-1:0] == '0) begin
                        n_state = S_DONE;
                    end else begin
                        // reduce the base: 1 * base mod m
                        mul_start = 1'b1;
                        mul_a     = one_mod;
                        mul_b     = i_base_value[W-1:0];
                        n_state   = S_RED_WAIT;
                    end
                end
            end
            S_RED_WAIT: begin
                if (mul_done) begin
                    n_pw    = mul_result;
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                priority if (r_exp == '0) begin
                    n_state = S_DONE;
                end else if (r_exp[0]) begin
                    mul_start = 1'b1;
                    mul_b     = r_acc;
                    n_state   = S_MUL_WAIT;
                end else begin
                    mul_start = 1'b1;
                    n_state   = S_SQR_WAIT;
                end
            end
            S_MUL_WAIT: begin
                if (mul_done) begin
                    n_acc = mul_result;
                    // skip the square after the top exponent bit
                    if ((r_exp >> 1) == '0) begin
                        n_state = S_DONE;
                    end else begin
                        mul_start = 1'b1;
                        n_state   = S_SQR_WAIT;
                    end
                end
            end
            S_SQR_WAIT: begin
                if (mul_done) begin
                    n_pw    = mul_result;
                    n_exp   = r_exp >> 1;
                    n_state = S_STEP;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_acc <= n_acc;
        r_pw  <= n_pw;
        r_exp <= n_exp;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = (r_state == S_DONE);
    assign o_power_result = FIELD_WIDTH'(r_acc);

    a_valid_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !busy)
        else $error("block still busy after result strobe");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("start transfer did not raise busy");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == S_RED_WAIT || r_state == S_MUL_WAIT
                      || r_state == S_SQR_WAIT))
        else $error("multiplier finished outside a wait state");

endmodule

// ===== src/mexp_mulmod.sv =====
// ----------------------------------------------------------------------------
// mexp_mulmod
// Bit-serial interleaved modular multiplier: result = a * b mod m.
// The multiplier b shifts out MSB first, one bit per cycle; the partial
// remainder is doubled, a is added on a set bit, and at most two multiples
// of m are taken off. The multiplicand a must already be below m.
// ----------------------------------------------------------------------------
module mexp_mulmod
    import mexp_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [OPERAND_WIDTH-1:0] i_a,
    input  logic [OPERAND_WIDTH-1:0] i_b,
    input  logic [OPERAND_WIDTH-1:0] i_m,
    output logic                     o_done,
    output logic [OPERAND_WIDTH-1:0] o_result
);

    localparam int W  = OPERAND_WIDTH;
    localparam int CW = $clog2(W + 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt,  n_cnt;
    logic [W-1:0]  r_a,    n_a;
    logic [W-1:0]  r_b,    n_b;
    logic [W-1:0]  r_m,    n_m;
    logic [W-1:0]  r_r,    n_r;

    logic [W+1:0]  sum;
    logic [W+1:0]  m1;
    logic [W+1:0]  m2;
    logic [W+1:0]  red;

    always_comb begin
        // sum < 3m since r < m and a < m
        sum = {1'b0, r_r, 1'b0} + (r_b[W-1] ? {2'b00, r_a} : '0);
        m1  = {2'b00, r_m};
        m2  = {1'b0, r_m, 1'b0};
        priority if (sum >= m2) begin
            red = sum - m2;
        end else if (sum >= m1) begin
            red = sum - m1;
        end else begin
            red = sum;
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_a    = r_a;
        n_b    = r_b;
        n_m    = r_m;
        n_r    = r_r;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(W);
            n_a    = i_a;
            n_b    = i_b;
            n_m    = i_m;
            n_r    = '0;
        end else if (r_busy) begin
            n_r   = red[W-1:0];
            n_b   = {r_b[W-2:0], 1'b0};
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_a <= n_a;
        r_b <= n_b;
        r_m <= n_m;
        r_r <= n_r;
    end

    assign o_done   = r_done;
    assign o_result = r_r;

    a_result_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_r < r_m))
        else $error("mulmod result not below modulus");

    a_busy_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0))
        else $error("mulmod busy with empty bit count");

    a_start_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> (r_busy && (r_cnt == CW'(W)) && !r_done))
        else $error("mulmod start did not load a full bit count");

endmodule
